/* sv/ihs_pkg.sv */
// Shared types, constants and decode functions for the image header size sniffer.
package ihs_pkg;

	localparam int unsigned HEADER_BYTES_DEF = 34;
	localparam int unsigned MIN_BYTES_DEF    = 18;

	localparam int unsigned POS_W     = 6;
	localparam int unsigned SCAN_W    = 17;
	localparam int unsigned LEAD_KEEP = 26;

	localparam logic [2:0] FMT_UNKNOWN = 3'd0;
	localparam logic [2:0] FMT_PNG     = 3'd1;
	localparam logic [2:0] FMT_BMP     = 3'd2;
	localparam logic [2:0] FMT_JPEG    = 3'd3;
	localparam logic [2:0] FMT_TGA     = 3'd4;

	localparam logic [7:0] MK_PREFIX   = 8'hFF;
	localparam logic [7:0] MK_SOI      = 8'hD8;
	localparam logic [7:0] MK_TEM      = 8'h01;
	localparam logic [7:0] MK_RST_LO   = 8'hD0;
	localparam logic [7:0] MK_RST_HI   = 8'hD7;
	localparam logic [7:0] MK_SOF_LO   = 8'hC0;
	localparam logic [7:0] MK_SOF_HI   = 8'hCF;
	localparam logic [7:0] MK_DHT      = 8'hC4;
	localparam logic [7:0] MK_JPG      = 8'hC8;
	localparam logic [7:0] MK_DAC      = 8'hCC;

	localparam logic [7:0] BMP_SIG0    = 8'h42;
	localparam logic [7:0] BMP_SIG1    = 8'h4D;
	localparam logic [7:0] TGA_RLE_BIT = 8'h08;
	localparam logic [7:0] TGA_CMP_BIT = 8'h02;
	localparam logic [7:0] TGA_X_BIT   = 8'h10;

	localparam logic [0:7][7:0] PNG_SIG = {8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	typedef logic [LEAD_KEEP-1:0][7:0] lead_t;

	// Everything the classifier needs once the last byte of a file has arrived.
	typedef struct packed {
		lead_t            lead;
		logic [POS_W-1:0] count;
		logic             sof_found;
		logic [POS_W-1:0] sof_pos;
		logic [3:0][7:0]  sof_bytes;
	} snap_t;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [31:0] height;
		logic [31:0] width;
	} result_t;

	function automatic logic is_sof(input logic [7:0] mk);
		return (mk >= MK_SOF_LO) && (mk <= MK_SOF_HI) && (mk != MK_DHT) &&
			(mk != MK_JPG) && (mk != MK_DAC);
	endfunction

	function automatic logic is_standalone(input logic [7:0] mk);
		return (mk == MK_SOI) || (mk == MK_TEM) || ((mk >= MK_RST_LO) && (mk <= MK_RST_HI));
	endfunction

endpackage

/* sv/image_header_size_sniffer.sv */
// After the last byte, the result passes the snapshot register and then the output register.
// Throughput: one byte per cycle unless stalled; the collector updates its state per transfer.
// A held result stalls input only when the snapshot stage is also full.
// Reset (asynchronous, active low) clears the collector, the snapshot and the output;
// the collector also returns to that state after each file's last byte.
module image_header_size_sniffer import ihs_pkg::*; #(
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int unsigned MIN_BYTES    = MIN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] header_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [31:0] image_width, [63:32] image_height, [66:64] format_code
);

	snap_t   snap_nxt, snap_s1;
	logic    snap_v_s1;
	result_t res_comb, res_q;
	logic    out_free, accept;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !snap_v_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	ihs_collect #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_collect (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.data   (s_tdata),
		.last   (s_tlast),
		.snap   (snap_nxt)
	);

	ihs_eval #(
		.MIN_BYTES(MIN_BYTES)
	) u_eval (
		.snap (snap_s1),
		.res  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1 <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			if (accept && s_tlast) begin
				snap_v_s1 <= 1'b1;
			end else if (out_free) begin
				snap_v_s1 <= 1'b0;
			end
			if (out_free) begin
				m_tvalid <= snap_v_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_s1 <= '0;
			res_q   <= '0;
		end else begin
			if (accept && s_tlast) begin
				snap_s1 <= snap_nxt;
			end
			if (out_free && snap_v_s1) begin
				res_q <= res_comb;
			end
		end
	end

	assign m_tdata = {5'b00000, res_q.fmt, res_q.height, res_q.width};

endmodule

/* sv/ihs_collect.sv */
// Byte collector: keeps the leading header bytes and walks the JPEG marker chain.
module ihs_collect import ihs_pkg::*; #(
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data,
	input  logic       last,
	output snap_t      snap
);

	localparam logic [2:0] PH_SEEK = 3'd0;
	localparam logic [2:0] PH_MARK = 3'd1;
	localparam logic [2:0] PH_LENH = 3'd2;
	localparam logic [2:0] PH_LENL = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	localparam logic [POS_W-1:0] HB = POS_W'(HEADER_BYTES);

	logic [POS_W-1:0]  pos_q;
	lead_t             lead_q, lead_nxt;
	logic [SCAN_W-1:0] next_q, next_nxt;
	logic [2:0]        phase_q, phase_nxt;
	logic [POS_W-1:0]  seg_q, seg_nxt;
	logic [7:0]        lenh_q, lenh_nxt;
	logic              found_q, found_nxt;
	logic [POS_W-1:0]  fpos_q, fpos_nxt;
	logic [3:0][7:0]   sofb_q, sofb_nxt;
	logic              in_range;
	logic [POS_W-1:0]  count_nxt;
	logic [POS_W-1:0]  off;

	always_comb begin
		in_range  = pos_q < HB;
		lead_nxt  = lead_q;
		count_nxt = pos_q;
		next_nxt  = next_q;
		phase_nxt = phase_q;
		seg_nxt   = seg_q;
		lenh_nxt  = lenh_q;
		found_nxt = found_q;
		fpos_nxt  = fpos_q;
		sofb_nxt  = sofb_q;
		off       = pos_q - fpos_q;
		if (in_range) begin
			count_nxt = pos_q + POS_W'(1);
			for (int i = 0; i < LEAD_KEEP; i++) begin
				if (pos_q == POS_W'(i)) begin
					lead_nxt[i] = data;
				end
			end
			case (phase_q)
				PH_SEEK: begin
					if (SCAN_W'(pos_q) == next_q) begin
						if (data == MK_PREFIX) begin
							phase_nxt = PH_MARK;
							seg_nxt   = pos_q;
						end else begin
							next_nxt = next_q + SCAN_W'(1);
						end
					end
				end
				PH_MARK: begin
					if (is_sof(data)) begin
						found_nxt = 1'b1;
						fpos_nxt  = seg_q;
						phase_nxt = PH_DONE;
					end else if (is_standalone(data)) begin
						next_nxt  = SCAN_W'(seg_q) + SCAN_W'(2);
						phase_nxt = PH_SEEK;
					end else begin
						phase_nxt = PH_LENH;
					end
				end
				PH_LENH: begin
					lenh_nxt  = data;
					phase_nxt = PH_LENL;
				end
				PH_LENL: begin
					if ({lenh_q, data} < 16'd2) begin
						// A length below two lands on the length bytes again; they hold no
						// marker prefix, so the scan carries on just after them.
						next_nxt = SCAN_W'(seg_q) + SCAN_W'(4);
					end else begin
						// The segment length counts its own two bytes but not the marker.
						next_nxt = SCAN_W'(seg_q) + SCAN_W'(2) + SCAN_W'({lenh_q, data});
					end
					phase_nxt = PH_SEEK;
				end
				PH_DONE: begin
					// Frame header: height at offsets five and six, width at seven and eight.
					for (int j = 0; j < 4; j++) begin
						if (off == POS_W'(j + 5)) begin
							sofb_nxt[j] = data;
						end
					end
				end
				default: begin
					phase_nxt = PH_DONE;
				end
			endcase
		end
	end

	always_comb begin
		snap.lead      = lead_nxt;
		snap.count     = count_nxt;
		snap.sof_found = found_nxt;
		snap.sof_pos   = fpos_nxt;
		snap.sof_bytes = sofb_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			lead_q  <= '0;
			next_q  <= SCAN_W'(2);
			phase_q <= PH_SEEK;
			seg_q   <= '0;
			lenh_q  <= '0;
			found_q <= 1'b0;
			fpos_q  <= '0;
			sofb_q  <= '0;
		end else if (accept) begin
			if (last) begin
				// The file is complete: start afresh for the next one.
				pos_q   <= '0;
				lead_q  <= '0;
				next_q  <= SCAN_W'(2);
				phase_q <= PH_SEEK;
				seg_q   <= '0;
				lenh_q  <= '0;
				found_q <= 1'b0;
				fpos_q  <= '0;
				sofb_q  <= '0;
			end else begin
				pos_q   <= count_nxt;
				lead_q  <= lead_nxt;
				next_q  <= next_nxt;
				phase_q <= phase_nxt;
				seg_q   <= seg_nxt;
				lenh_q  <= lenh_nxt;
				found_q <= found_nxt;
				fpos_q  <= fpos_nxt;
				sofb_q  <= sofb_nxt;
			end
		end
	end

endmodule

/* sv/ihs_eval.sv */
// Format classifier: turns a captured header snapshot into width, height and format.
module ihs_eval import ihs_pkg::*; #(
	parameter int unsigned MIN_BYTES = MIN_BYTES_DEF
) (
	input  snap_t   snap,
	output result_t res
);

	localparam logic [POS_W-1:0] MINB = POS_W'(MIN_BYTES);

	logic        is_png, is_bmp, is_jpeg, is_tga, sof_ok;
	logic [31:0] bmp_h_raw;
	logic [7:0]  tga_flags;

	always_comb begin
		is_png = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (snap.lead[i] != PNG_SIG[i]) begin
				is_png = 1'b0;
			end
		end
		is_bmp    = (snap.lead[0] == BMP_SIG0) && (snap.lead[1] == BMP_SIG1);
		is_jpeg   = (snap.lead[0] == MK_PREFIX) && (snap.lead[1] == MK_SOI);
		tga_flags = snap.lead[1];
		is_tga    = ((tga_flags & TGA_RLE_BIT) != 8'h00) && (snap.lead[2] == 8'h00) &&
			(snap.lead[3] == 8'h00) && (snap.lead[4] == 8'h00) && (snap.lead[5] == 8'h00) &&
			((tga_flags & TGA_CMP_BIT) == 8'h00) && ((tga_flags & TGA_X_BIT) == 8'h00);
		// A frame header counts only if its fields lie well inside the kept bytes.
		sof_ok    = snap.sof_found &&
			((7'(snap.sof_pos) + 7'd9) < 7'(snap.count));
		bmp_h_raw = {snap.lead[25], snap.lead[24], snap.lead[23], snap.lead[22]};

		res = '0;
		if (snap.count < MINB) begin
			res = '0;
		end else if (is_png) begin
			res.fmt    = FMT_PNG;
			res.width  = {snap.lead[16], snap.lead[17], snap.lead[18], snap.lead[19]};
			res.height = {snap.lead[20], snap.lead[21], snap.lead[22], snap.lead[23]};
		end else if (is_bmp) begin
			res.fmt    = FMT_BMP;
			res.width  = {snap.lead[21], snap.lead[20], snap.lead[19], snap.lead[18]};
			res.height = bmp_h_raw[31] ? (32'd0 - bmp_h_raw) : bmp_h_raw;
		end else if (is_jpeg) begin
			res.fmt = FMT_JPEG;
			if (sof_ok) begin
				res.height = {16'h0000, snap.sof_bytes[0], snap.sof_bytes[1]};
				res.width  = {16'h0000, snap.sof_bytes[2], snap.sof_bytes[3]};
			end
		end else if (is_tga) begin
			res.fmt    = FMT_TGA;
			res.width  = {16'h0000, snap.lead[13], snap.lead[12]};
			res.height = {16'h0000, snap.lead[15], snap.lead[14]};
		end
	end

endmodule

/* dv/tb_image_header_size_sniffer.sv */
// Self-checking testbench for the image header size sniffer: streams files, predicts each result.
module tb_image_header_size_sniffer;
	timeunit 1ns;
	timeprecision 1ps;

	import ihs_pkg::*;

	localparam int unsigned KEEP_BYTES     = HEADER_BYTES_DEF;
	localparam int unsigned SHORTEST_FILE  = MIN_BYTES_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned PHASE_BYTES    = 200;
	localparam int unsigned PHASE_FILES    = 6;

	typedef struct packed {
		logic [31:0] width;
		logic [31:0] height;
		logic [2:0]  fmt;
	} dims_t;

	typedef enum int {
		FILE_PNG, FILE_BMP, FILE_JPEG, FILE_TGA, FILE_NOISE, FILE_BROKEN, FILE_SHORT, FILE_LONG
	} file_kind_e;

	class header_scoreboard;
		byte unsigned kept[64];
		int unsigned  kept_n;
		dims_t        expected_dims[$];
		int unsigned  errors;

		function new();
			clear_header();
			errors = 0;
		endfunction

		function void clear_header();
			foreach (kept[i]) kept[i] = 8'h00;
			kept_n = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function int unsigned pending();
			return expected_dims.size();
		endfunction

		// Positions at or past the number of kept bytes read as zero.
		function logic [31:0] byte_at(int unsigned i);
			if (i >= kept_n || i >= 64) return 32'd0;
			return {24'd0, kept[i]};
		endfunction

		function logic [31:0] word_be16(int unsigned i);
			return (byte_at(i) << 8) | byte_at(i + 1);
		endfunction

		function logic [31:0] word_le32(int unsigned i);
			return byte_at(i) | (byte_at(i + 1) << 8) | (byte_at(i + 2) << 16) |
				(byte_at(i + 3) << 24);
		endfunction

		function dims_t sniff_dimensions();
			dims_t       d;
			logic        png_ok;
			logic [31:0] hv;
			logic [7:0]  mk;
			logic [7:0]  flags;
			int unsigned pos;

			d = '0;
			if (kept_n < SHORTEST_FILE) return d;

			png_ok = 1'b1;
			for (int i = 0; i < 8; i++)
				if (byte_at(i) != {24'd0, PNG_SIG[i]}) png_ok = 1'b0;
			if (png_ok) begin
				d.width  = (byte_at(16) << 24) | (byte_at(17) << 16) | (byte_at(18) << 8) |
					byte_at(19);
				d.height = (byte_at(20) << 24) | (byte_at(21) << 16) | (byte_at(22) << 8) |
					byte_at(23);
				d.fmt    = FMT_PNG;
				return d;
			end

			if (byte_at(0) == BMP_SIG0 && byte_at(1) == BMP_SIG1) begin
				hv = word_le32(22);
				if (hv[31]) hv = 32'd0 - hv;
				d.width  = word_le32(18);
				d.height = hv;
				d.fmt    = FMT_BMP;
				return d;
			end

			if (byte_at(0) == MK_PREFIX && byte_at(1) == MK_SOI) begin
				d.fmt = FMT_JPEG;
				pos = 2;
				while (pos + 9 < kept_n) begin
					if (byte_at(pos) != MK_PREFIX) begin
						pos++;
					end else begin
						mk = 8'(byte_at(pos + 1));
						if (mk >= MK_SOF_LO && mk <= MK_SOF_HI && mk != MK_DHT &&
							mk != MK_JPG && mk != MK_DAC) begin
							d.height = word_be16(pos + 5);
							d.width  = word_be16(pos + 7);
							return d;
						end
						if (mk == MK_SOI || mk == MK_TEM || (mk >= MK_RST_LO && mk <= MK_RST_HI))
							pos += 2;
						else
							pos += 2 + word_be16(pos + 2);
					end
				end
				return d;
			end

			flags = 8'(byte_at(1));
			if ((flags & TGA_RLE_BIT) != 0 && byte_at(2) == 0 && byte_at(3) == 0 &&
				byte_at(4) == 0 && byte_at(5) == 0 && (flags & TGA_CMP_BIT) == 0 &&
				(flags & TGA_X_BIT) == 0) begin
				d.width  = byte_at(12) | (byte_at(13) << 8);
				d.height = byte_at(14) | (byte_at(15) << 8);
				d.fmt    = FMT_TGA;
			end
			return d;
		endfunction

		// Bytes past the kept window are dropped, but their last flag still closes the file.
		function void note_byte(logic [7:0] b, logic last);
			if (kept_n < KEEP_BYTES) begin
				kept[kept_n] = b;
				kept_n++;
			end
			if (last) begin
				expected_dims.push_back(sniff_dimensions());
				clear_header();
			end
		endfunction

		task check_result(logic [71:0] data);
			dims_t want;
			if (expected_dims.size() == 0) begin
				report($sformatf("result with nothing expected, data %h", data));
				return;
			end
			want = expected_dims.pop_front();
			if (data[31:0] !== want.width)
				report($sformatf("image_width %h, expected %h", data[31:0], want.width));
			if (data[63:32] !== want.height)
				report($sformatf("image_height %h, expected %h", data[63:32], want.height));
			if (data[66:64] !== want.fmt)
				report($sformatf("format_code %0d, expected %0d", data[66:64], want.fmt));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	header_scoreboard sb = new();

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned hold_request;
	int unsigned quiet_cycles;
	int unsigned bytes_sent;
	int unsigned files_sent;
	logic        moved;
	byte unsigned file_bytes[$];

	image_header_size_sniffer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold-off when asked for.
	initial begin
		int unsigned held;
		m_tready = 1'b0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
			end
			if (held != 0) begin
				m_tready <= 1'b0;
				held--;
			end else begin
				m_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (s_tvalid && s_tready) begin
				sb.note_byte(s_tdata, s_tlast);
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_size();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(1, 4096);
			default: return $urandom;
		endcase
	endfunction

	function automatic void make_file(file_kind_e kind);
		byte unsigned img[64];
		file_kind_e   shape;
		int unsigned  n;
		int unsigned  p;
		int unsigned  seg_len;
		logic [31:0]  w;
		logic [31:0]  h;
		logic [7:0]   mk;

		foreach (img[i]) img[i] = 8'($urandom_range(255));
		shape = kind;
		if (kind == FILE_BROKEN || kind == FILE_SHORT || kind == FILE_LONG)
			shape = file_kind_e'($urandom_range(FILE_TGA));
		w = pick_size();
		h = pick_size();

		case (shape)
			FILE_PNG: begin
				for (int i = 0; i < 8; i++) img[i] = PNG_SIG[i];
				{img[8], img[9], img[10], img[11]} = 32'd13;
				{img[12], img[13], img[14], img[15]} = "IHDR";
				{img[16], img[17], img[18], img[19]} = w;
				{img[20], img[21], img[22], img[23]} = h;
			end
			FILE_BMP: begin
				img[0] = BMP_SIG0;
				img[1] = BMP_SIG1;
				{img[21], img[20], img[19], img[18]} = w;
				{img[25], img[24], img[23], img[22]} = h;
			end
			FILE_JPEG: begin
				img[0] = MK_PREFIX;
				img[1] = MK_SOI;
				p = 2;
				while (p < 54) begin
					case ($urandom_range(9))
						0: begin
							img[p] = 8'($urandom_range(254));
							p++;
						end
						1, 2: begin
							img[p] = MK_PREFIX;
							case ($urandom_range(2))
								0: img[p + 1] = MK_SOI;
								1: img[p + 1] = MK_TEM;
								default: img[p + 1] = 8'(MK_RST_LO + $urandom_range(7));
							endcase
							p += 2;
						end
						3, 4, 5: begin
							img[p] = MK_PREFIX;
							case ($urandom_range(4))
								0: img[p + 1] = MK_DHT;
								1: img[p + 1] = MK_JPG;
								2: img[p + 1] = MK_DAC;
								default: img[p + 1] = 8'(8'hE0 + $urandom_range(15));
							endcase
							seg_len = ($urandom_range(15) == 0) ? $urandom_range(65535) :
								$urandom_range(8);
							{img[p + 2], img[p + 3]} = seg_len[15:0];
							// A length below two leaves the length bytes in place before the
							// next item.
							p += (seg_len < 2) ? 4 : 2 + seg_len;
						end
						default: begin
							mk = 8'(MK_SOF_LO + $urandom_range(15));
							if (mk == MK_DHT || mk == MK_JPG || mk == MK_DAC) mk = MK_SOF_LO;
							img[p] = MK_PREFIX;
							img[p + 1] = mk;
							{img[p + 2], img[p + 3]} = 16'd17;
							img[p + 4] = 8'h08;
							{img[p + 5], img[p + 6]} = h[15:0];
							{img[p + 7], img[p + 8]} = w[15:0];
							p = 64;
						end
					endcase
				end
			end
			FILE_TGA: begin
				img[1] = 8'(($urandom_range(255) | TGA_RLE_BIT) & ~(TGA_CMP_BIT | TGA_X_BIT));
				for (int i = 2; i < 6; i++) img[i] = 8'h00;
				{img[13], img[12]} = w[15:0];
				{img[15], img[14]} = h[15:0];
			end
			default: ;
		endcase

		if (kind == FILE_BROKEN) img[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);

		case (kind)
			FILE_SHORT: n = $urandom_range(1, SHORTEST_FILE - 1);
			FILE_LONG:  n = $urandom_range(KEEP_BYTES + 1, 63);
			default: begin
				case ($urandom_range(7))
					0: n = SHORTEST_FILE;
					1: n = KEEP_BYTES;
					default: n = $urandom_range(SHORTEST_FILE, KEEP_BYTES);
				endcase
			end
		endcase

		file_bytes.delete();
		for (int i = 0; i < n; i++) file_bytes.push_back(img[i]);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
	endtask

	task automatic send_random_files();
		int unsigned pick;
		bytes_sent = 0;
		files_sent = 0;
		while (bytes_sent < PHASE_BYTES || files_sent < PHASE_FILES) begin
			pick = $urandom_range(99);
			if (pick < 16)      make_file(FILE_PNG);
			else if (pick < 32) make_file(FILE_BMP);
			else if (pick < 56) make_file(FILE_JPEG);
			else if (pick < 70) make_file(FILE_TGA);
			else if (pick < 78) make_file(FILE_NOISE);
			else if (pick < 86) make_file(FILE_BROKEN);
			else if (pick < 93) make_file(FILE_SHORT);
			else                make_file(FILE_LONG);
			send_file();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		tx_idle_pct  = 12;
		rx_idle_pct  = 49;
		hold_request = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A lone byte and a two-byte JPEG start are both too short to classify.
		file_bytes = '{8'h00};
		send_file();
		file_bytes = '{MK_PREFIX, MK_SOI};
		send_file();
		file_bytes = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
			8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
		send_file();

		send_random_files();

		tx_idle_pct = 49;
		rx_idle_pct = 12;
		send_random_files();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// The receiver stops for a long stretch so that the block fills and refuses transfers.
		hold_request = HOLD_CYCLES;
		send_random_files();

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
